// ----- design/assert_macros.svh -----
// Assertion macros used by the cipher top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that cons holds at the clock edge after ante, outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle assertion failed");

// Checks that expr holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("invariant assertion failed");

`endif

// ----- design/spn_pkg.sv -----
// Package with the cipher's constants, types and round functions.
package spn_pkg;

   localparam int BYTE_W              = 8;
   localparam int NIBBLE_W            = 4;
   localparam int PERM_FIELD_W        = 3;
   localparam int KEY_W               = 32;
   localparam int SBOX_W              = 64;
   localparam int PERM_W              = 24;
   localparam int CSR_INDEX_W         = 2;
   localparam int CSR_DATA_W          = 64;
   localparam int ROUND_COUNT_DEFAULT = 3;
   localparam int LAST_KEY_ROUND      = 2;
   localparam int WHITEN_KEY_BYTE     = 3;

   localparam logic [KEY_W-1:0]  ROUND_KEYS_RESET = 32'h0000_0000;
   localparam logic [SBOX_W-1:0] SBOX_TABLE_RESET = 64'hFEDC_BA98_7654_3210;
   localparam logic [PERM_W-1:0] PERM_MAP_RESET   = 24'hFA_C688;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ROUND_KEYS = 2'd0,
      CSR_SBOX_TABLE = 2'd1,
      CSR_PERM_MAP   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [KEY_W-1:0]  round_keys;
      logic [SBOX_W-1:0] sbox_table;
      logic [PERM_W-1:0] perm_map;
   } cfg_type;

   function automatic logic [NIBBLE_W-1:0] sbox_lookup(
      input logic [SBOX_W-1:0]   table_bits,
      input logic [NIBBLE_W-1:0] nib
   );
      return table_bits[{nib, 2'b00} +: NIBBLE_W];
   endfunction

   function automatic logic [BYTE_W-1:0] substitute(
      input logic [SBOX_W-1:0] table_bits,
      input logic [BYTE_W-1:0] b
   );
      return {sbox_lookup(table_bits, b[BYTE_W-1:NIBBLE_W]),
              sbox_lookup(table_bits, b[NIBBLE_W-1:0])};
   endfunction

   // Result bit 7-i takes input bit 7-p(i).
   function automatic logic [BYTE_W-1:0] permute(
      input logic [PERM_W-1:0] map,
      input logic [BYTE_W-1:0] b
   );
      logic [BYTE_W-1:0]       r;
      logic [PERM_FIELD_W-1:0] src;
      r = '0;
      for (int i = 0; i < BYTE_W; i++) begin
         src = map[i*PERM_FIELD_W +: PERM_FIELD_W];
         r[BYTE_W-1-i] = b[~src];
      end
      return r;
   endfunction

endpackage

// ----- design/spn_csr.sv -----
// Configuration registers for the key, the S-box and the bit permutation.
module spn_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [spn_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [spn_pkg::CSR_DATA_W-1:0]       csr_wdata,
   output spn_pkg::cfg_type                     cfg
);

   spn_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            spn_pkg::CSR_ROUND_KEYS: cfg_in.round_keys = csr_wdata[spn_pkg::KEY_W-1:0];
            spn_pkg::CSR_SBOX_TABLE: cfg_in.sbox_table = csr_wdata[spn_pkg::SBOX_W-1:0];
            spn_pkg::CSR_PERM_MAP:   cfg_in.perm_map   = csr_wdata[spn_pkg::PERM_W-1:0];
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.round_keys <= spn_pkg::ROUND_KEYS_RESET;
         cfg_ff.sbox_table <= spn_pkg::SBOX_TABLE_RESET;
         cfg_ff.perm_map   <= spn_pkg::PERM_MAP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- design/spn_round.sv -----
// One registered cipher round: key XOR, nibble substitution, bit permutation.
module spn_round (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             valid_in,
   input  logic [spn_pkg::BYTE_W-1:0]       data_in,
   input  logic [spn_pkg::BYTE_W-1:0]       key_byte,
   input  logic [spn_pkg::SBOX_W-1:0]       sbox_table,
   input  logic [spn_pkg::PERM_W-1:0]       perm_map,
   output logic                             valid_out,
   output logic [spn_pkg::BYTE_W-1:0]       data_out
);

   logic                         valid_ff;
   logic [spn_pkg::BYTE_W-1:0]   data_ff, data_in_mixed;

   always_comb begin
      data_in_mixed = spn_pkg::permute(perm_map,
         spn_pkg::substitute(sbox_table, data_in ^ key_byte));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (valid_in) begin
         data_ff <= data_in_mixed;
      end
   end

   assign valid_out = valid_ff;
   assign data_out  = data_ff;

endmodule

// ----- design/spn_byte_cipher_encrypt.sv -----
// Top level of the pipelined 8-bit substitution-permutation encryptor.
//
// The block encrypts one byte per item and takes a new item in every clock
// cycle; busy is always low. Each round is one register stage and the final
// key XOR is a last output register, so the result appears on rsp_cipher_byte
// with rsp_strobe high for one cycle, after the round registers and then the
// output register. Results cannot be held off and come out in order. The key,
// S-box and permutation registers feed every stage directly, so they must only
// be written while no item is in flight.
`include "assert_macros.svh"

module spn_byte_cipher_encrypt #(
   parameter int ROUND_COUNT = spn_pkg::ROUND_COUNT_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [spn_pkg::BYTE_W-1:0]        req_plain_byte,
   output logic                              rsp_strobe,
   output logic [spn_pkg::BYTE_W-1:0]        rsp_cipher_byte,
   input  logic                              csr_we,
   input  logic [spn_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [spn_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   spn_pkg::cfg_type             cfg;
   logic                         stage_valid [ROUND_COUNT+1];
   logic [spn_pkg::BYTE_W-1:0]   stage_data  [ROUND_COUNT+1];
   logic                         strobe_ff;
   logic [spn_pkg::BYTE_W-1:0]   cipher_ff;
   logic                         key_write;
   logic [spn_pkg::KEY_W-1:0]    key_wdata;

   spn_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   assign busy           = 1'b0;
   assign stage_valid[0] = start;
   assign stage_data[0]  = req_plain_byte;

   for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
      localparam int KEY_SEL = (r < spn_pkg::LAST_KEY_ROUND) ? r : spn_pkg::LAST_KEY_ROUND;

      spn_round u_round (
         .clock      (clock),
         .reset      (reset),
         .valid_in   (stage_valid[r]),
         .data_in    (stage_data[r]),
         .key_byte   (cfg.round_keys[KEY_SEL*spn_pkg::BYTE_W +: spn_pkg::BYTE_W]),
         .sbox_table (cfg.sbox_table),
         .perm_map   (cfg.perm_map),
         .valid_out  (stage_valid[r+1]),
         .data_out   (stage_data[r+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= stage_valid[ROUND_COUNT];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_valid[ROUND_COUNT]) begin
         cipher_ff <= stage_data[ROUND_COUNT] ^
            cfg.round_keys[spn_pkg::WHITEN_KEY_BYTE*spn_pkg::BYTE_W +: spn_pkg::BYTE_W];
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_cipher_byte = cipher_ff;

   assign key_write = csr_we && csr_index == spn_pkg::CSR_ROUND_KEYS;
   assign key_wdata = csr_wdata[spn_pkg::KEY_W-1:0];

   `ASSERT_NEXT(a_last_round_strobes, clock, reset, stage_valid[ROUND_COUNT], rsp_strobe)
   `ASSERT_ALWAYS(a_strobe_from_start, clock, reset, !rsp_strobe || $past(start, ROUND_COUNT + 1))
   `ASSERT_NEXT(a_key_write, clock, reset, key_write, cfg.round_keys == $past(key_wdata))

endmodule

// ----- tb/sv/spn_cipher_tracker_pkg.sv -----
// Scoreboard package: a byte cipher predictor and an in-order store of expected ciphertext.
package spn_cipher_tracker_pkg;
   import spn_pkg::*;

   localparam int unsigned MAX_REPORTS = 10;

   class spn_cipher_tracker;
      int unsigned       num_rounds;
      logic [KEY_W-1:0]  keys;
      logic [SBOX_W-1:0] sbox_bits;
      logic [PERM_W-1:0] perm_bits;
      logic [BYTE_W-1:0] expected_cipher[$];
      int unsigned       mismatches;

      function new(int unsigned rounds);
         num_rounds = rounds;
         keys       = ROUND_KEYS_RESET;
         sbox_bits  = SBOX_TABLE_RESET;
         perm_bits  = PERM_MAP_RESET;
         mismatches = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         case (index)
            CSR_ROUND_KEYS: keys = data[KEY_W-1:0];
            CSR_SBOX_TABLE: sbox_bits = data[SBOX_W-1:0];
            CSR_PERM_MAP:   perm_bits = data[PERM_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [BYTE_W-1:0] encrypt_byte(logic [BYTE_W-1:0] plain);
         logic [BYTE_W-1:0]       m;
         logic [BYTE_W-1:0]       s;
         logic [PERM_FIELD_W-1:0] src;
         int unsigned             kb;
         m = plain;
         for (int unsigned r = 0; r < num_rounds; r++) begin
            kb = (r < LAST_KEY_ROUND) ? r : LAST_KEY_ROUND;
            m = m ^ keys[kb*BYTE_W +: BYTE_W];
            s = {sbox_bits[NIBBLE_W*m[7:4] +: NIBBLE_W],
                 sbox_bits[NIBBLE_W*m[3:0] +: NIBBLE_W]};
            for (int i = 0; i < BYTE_W; i++) begin
               src = perm_bits[i*PERM_FIELD_W +: PERM_FIELD_W];
               m[BYTE_W-1-i] = s[BYTE_W-1-src];
            end
         end
         return m ^ keys[WHITEN_KEY_BYTE*BYTE_W +: BYTE_W];
      endfunction

      function void note_plain(logic [BYTE_W-1:0] plain);
         expected_cipher.push_back(encrypt_byte(plain));
      endfunction

      function void check_cipher(logic [BYTE_W-1:0] got);
         logic [BYTE_W-1:0] want;
         if (expected_cipher.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("cipher byte %02h arrived with no item pending", got);
            return;
         end
         want = expected_cipher.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("cipher byte mismatch: expected %02h, got %02h", want, got);
         end
      endfunction

      function int unsigned pending();
         return expected_cipher.size();
      endfunction

      function bit clean();
         return mismatches == 0 && expected_cipher.size() == 0;
      endfunction
   endclass

endpackage

// ----- tb/sv/tb.sv -----
// Top-level testbench of the byte cipher encryptor with directed and random traffic.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import spn_pkg::*;
   import spn_cipher_tracker_pkg::*;

   localparam int CLOCK_HALF      = 5;
   localparam int RESET_CYCLES    = 7;
   localparam int NUM_ROUNDS      = ROUND_COUNT_DEFAULT;
   localparam int DRAIN_CYCLES    = NUM_ROUNDS + 5;
   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int RANDOM_PHASES   = 10;
   localparam int ITEMS_PER_PHASE = 73;
   localparam int MAX_GAP         = 17;
   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_UNUSED = 2'd3;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic [BYTE_W-1:0]      req_plain_byte;
   logic                   rsp_strobe;
   logic [BYTE_W-1:0]      rsp_cipher_byte;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   logic [BYTE_W-1:0] corner_bytes [8] = '{8'h00, 8'hFF, 8'h01, 8'h80,
                                           8'h55, 8'hAA, 8'h0F, 8'hF0};
   int unsigned       quiet_cycles = 0;
   spn_cipher_tracker tracker;

   always #CLOCK_HALF clock = ~clock;

   spn_byte_cipher_encrypt #(
      .ROUND_COUNT(NUM_ROUNDS)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_plain_byte (req_plain_byte),
      .rsp_strobe     (rsp_strobe),
      .rsp_cipher_byte(rsp_cipher_byte),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) tracker.check_cipher(rsp_cipher_byte);
         if (csr_we) tracker.write_reg(csr_index, csr_wdata);
         if (start && !busy) tracker.note_plain(req_plain_byte);
         if (rsp_strobe || csr_we || (start && !busy)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   task automatic send_plain(input logic [BYTE_W-1:0] plain, input int unsigned gap);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_plain_byte <= plain;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic settle();
      start <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic program_regs(input logic [KEY_W-1:0] keys, input logic [SBOX_W-1:0] sbox,
                               input logic [PERM_W-1:0] perm, input bit poke_unused);
      csr_we    <= 1'b1;
      csr_index <= CSR_ROUND_KEYS;
      csr_wdata <= CSR_DATA_W'(keys);
      @(posedge clock);
      csr_index <= CSR_SBOX_TABLE;
      csr_wdata <= sbox;
      @(posedge clock);
      csr_index <= CSR_PERM_MAP;
      csr_wdata <= CSR_DATA_W'(perm);
      @(posedge clock);
      if (poke_unused) begin
         csr_index <= CSR_INDEX_UNUSED;
         csr_wdata <= {$urandom, $urandom};
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   function automatic logic [KEY_W-1:0] pick_keys();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [SBOX_W-1:0] pick_sbox();
      logic [SBOX_W-1:0]   bits;
      logic [NIBBLE_W-1:0] tmp;
      int unsigned         j;
      case ($urandom_range(0, 5))
         0: bits = SBOX_TABLE_RESET;
         1: bits = '0;
         2: bits = '1;
         3: begin
            bits = SBOX_TABLE_RESET;
            for (int k = 15; k > 0; k--) begin
               j = $urandom_range(0, k);
               tmp = bits[k*NIBBLE_W +: NIBBLE_W];
               bits[k*NIBBLE_W +: NIBBLE_W] = bits[j*NIBBLE_W +: NIBBLE_W];
               bits[j*NIBBLE_W +: NIBBLE_W] = tmp;
            end
         end
         default: bits = {$urandom, $urandom};
      endcase
      return bits;
   endfunction

   function automatic logic [PERM_W-1:0] pick_perm();
      case ($urandom_range(0, 5))
         0:       return PERM_MAP_RESET;
         1:       return '0;
         2:       return '1;
         default: return PERM_W'($urandom);
      endcase
   endfunction

   function automatic logic [BYTE_W-1:0] pick_plain();
      if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      return BYTE_W'($urandom);
   endfunction

   initial begin
      int unsigned gap_odds;
      int unsigned gap;
      tracker        = new(NUM_ROUNDS);
      reset          <= 1'b1;
      start          <= 1'b0;
      req_plain_byte <= '0;
      csr_we         <= 1'b0;
      csr_index      <= CSR_ROUND_KEYS;
      csr_wdata      <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (corner_bytes[k]) send_plain(corner_bytes[k], 0);
      settle();
      program_regs('1, '0, '1, 1'b1);
      for (int k = 0; k < 4; k++) send_plain(corner_bytes[k], k);
      settle();
      program_regs($urandom, '1, '0, 1'b0);
      for (int k = 4; k < 8; k++) send_plain(corner_bytes[k], 0);
      settle();
      program_regs('1, SBOX_TABLE_RESET, PERM_MAP_RESET, 1'b1);
      for (int k = 0; k < 4; k++) send_plain(corner_bytes[k], 0);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         settle();
         program_regs(pick_keys(), pick_sbox(), pick_perm(), $urandom_range(0, 3) == 0);
         gap_odds = (p >= RANDOM_PHASES - 2) ? 0 : $urandom_range(0, 4);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            gap = (gap_odds != 0 && $urandom_range(0, 9) < gap_odds) ?
                  $urandom_range(1, MAX_GAP) : 0;
            send_plain(pick_plain(), gap);
         end
      end
      settle();

      if (tracker.clean()) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
